/* hw/rtl/sfu_pkg.sv */
// ----------------------------------------------------------------------------
// sfu_pkg
// Shared types and codes for the stack frame unit (PUSHA/POPA/ENTER/LEAVE).
// ----------------------------------------------------------------------------
package sfu_pkg;

	localparam logic [1:0] CMD_PUSHA = 2'd0;
	localparam logic [1:0] CMD_POPA  = 2'd1;
	localparam logic [1:0] CMD_ENTER = 2'd2;
	localparam logic [1:0] CMD_LEAVE = 2'd3;

	localparam logic ACCESS_READ  = 1'b0;
	localparam logic ACCESS_WRITE = 1'b1;

	// operand selects: 0..7 follow the register file order ax cx dx bx sp bp si di
	localparam logic [3:0] SEL_AX  = 4'd0;
	localparam logic [3:0] SEL_CX  = 4'd1;
	localparam logic [3:0] SEL_DX  = 4'd2;
	localparam logic [3:0] SEL_BX  = 4'd3;
	localparam logic [3:0] SEL_SP  = 4'd4;
	localparam logic [3:0] SEL_BP  = 4'd5;
	localparam logic [3:0] SEL_SI  = 4'd6;
	localparam logic [3:0] SEL_DI  = 4'd7;
	localparam logic [3:0] SEL_SP0 = 4'd8;
	localparam logic [3:0] SEL_TMP = 4'd9;
	localparam logic [3:0] SEL_FP  = 4'd10;

	localparam int STORE_AW = 16;
	localparam int NEST_BITS = 5;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] stack_seg;
		logic [15:0] reg_ax;
		logic [15:0] reg_cx;
		logic [15:0] reg_dx;
		logic [15:0] reg_bx;
		logic [15:0] reg_sp;
		logic [15:0] reg_bp;
		logic [15:0] reg_si;
		logic [15:0] reg_di;
		logic [15:0] frame_bytes;
		logic [7:0]  nest_level;
	} req_t;

	typedef struct packed {
		logic        access_kind;
		logic [19:0] access_addr;
		logic [15:0] access_data;
		logic        last;
		logic [15:0] new_ax;
		logic [15:0] new_cx;
		logic [15:0] new_dx;
		logic [15:0] new_bx;
		logic [15:0] new_sp;
		logic [15:0] new_bp;
		logic [15:0] new_si;
		logic [15:0] new_di;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_ADDR, ST_WLO, ST_WHI, ST_RLO, ST_RHI, ST_RCAP, ST_EMIT
	} state_t;

	typedef enum logic [3:0] {
		DP_NOP, DP_CLR, DP_LOAD, DP_ADDR, DP_WR_LO, DP_WR_HI,
		DP_RD_LO, DP_RD_HI, DP_RD_CAP, DP_EMIT
	} dp_op_t;

	typedef enum logic [2:0] {
		ACC_PUSH, ACC_POP, ACC_POP_SKIP, ACC_LEAVE, ACC_COPY
	} acc_t;

	typedef struct packed {
		dp_op_t     op;
		acc_t       acc;
		logic [3:0] sel;
		logic       latch_fp;
		logic       last;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] level;
		logic       clr_last;
		logic       out_free;
	} dp_stat_t;

endpackage

/* hw/rtl/sfu_ctrl.sv */
// ----------------------------------------------------------------------------
// sfu_ctrl
// Sequencer: walks the stack accesses of each instruction and drives the
// datapath one micro step per cycle, except while it waits on a stalled result.
// ----------------------------------------------------------------------------
module sfu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  sfu_pkg::dp_stat_t stat,
	output sfu_pkg::dp_cmd_t  dcmd
);

	sfu_pkg::state_t state_q, state_d;
	logic [5:0] step_q;
	logic [4:0] copies;
	logic [5:0] enter_last;
	sfu_pkg::acc_t acc;
	logic [3:0] sel;
	logic latch_fp;
	logic is_last;

	// access plan for the current step
	always_comb begin
		copies = (stat.level[sfu_pkg::NEST_BITS-1:0] == '0) ? 5'd0 :
			stat.level[sfu_pkg::NEST_BITS-1:0] - 5'd1;
		enter_last = (stat.level == 8'd0) ? 6'd0 : {copies, 1'b1};
		acc = sfu_pkg::ACC_PUSH;
		sel = sfu_pkg::SEL_AX;
		latch_fp = 1'b0;
		is_last = 1'b0;
		unique case (stat.cmd)
			sfu_pkg::CMD_PUSHA: begin
				acc = sfu_pkg::ACC_PUSH;
				case (step_q[2:0])
					3'd0: sel = sfu_pkg::SEL_AX;
					3'd1: sel = sfu_pkg::SEL_CX;
					3'd2: sel = sfu_pkg::SEL_DX;
					3'd3: sel = sfu_pkg::SEL_BX;
					3'd4: sel = sfu_pkg::SEL_SP0;
					3'd5: sel = sfu_pkg::SEL_BP;
					3'd6: sel = sfu_pkg::SEL_SI;
					default: sel = sfu_pkg::SEL_DI;
				endcase
				is_last = (step_q == 6'd7);
			end
			sfu_pkg::CMD_POPA: begin
				acc = (step_q == 6'd3) ? sfu_pkg::ACC_POP_SKIP : sfu_pkg::ACC_POP;
				case (step_q[2:0])
					3'd0: sel = sfu_pkg::SEL_DI;
					3'd1: sel = sfu_pkg::SEL_SI;
					3'd2: sel = sfu_pkg::SEL_BP;
					3'd3: sel = sfu_pkg::SEL_BX;
					3'd4: sel = sfu_pkg::SEL_DX;
					3'd5: sel = sfu_pkg::SEL_CX;
					default: sel = sfu_pkg::SEL_AX;
				endcase
				is_last = (step_q == 6'd6);
			end
			sfu_pkg::CMD_ENTER: begin
				if (step_q == 6'd0) begin
					acc = sfu_pkg::ACC_PUSH;
					sel = sfu_pkg::SEL_BP;
					latch_fp = 1'b1;
				end else if (step_q == enter_last) begin
					acc = sfu_pkg::ACC_PUSH;
					sel = sfu_pkg::SEL_FP;
				end else if (step_q[0]) begin
					acc = sfu_pkg::ACC_COPY;
					sel = sfu_pkg::SEL_TMP;
				end else begin
					acc = sfu_pkg::ACC_PUSH;
					sel = sfu_pkg::SEL_TMP;
				end
				is_last = (step_q == enter_last);
			end
			default: begin
				acc = sfu_pkg::ACC_LEAVE;
				sel = sfu_pkg::SEL_BP;
				is_last = 1'b1;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sfu_pkg::ST_CLEAR: if (stat.clr_last) state_d = sfu_pkg::ST_IDLE;
			sfu_pkg::ST_IDLE:  if (req_valid) state_d = sfu_pkg::ST_ADDR;
			sfu_pkg::ST_ADDR:  state_d = (acc == sfu_pkg::ACC_PUSH) ? sfu_pkg::ST_WLO :
				sfu_pkg::ST_RLO;
			sfu_pkg::ST_WLO:   state_d = sfu_pkg::ST_WHI;
			sfu_pkg::ST_WHI:   state_d = sfu_pkg::ST_EMIT;
			sfu_pkg::ST_RLO:   state_d = sfu_pkg::ST_RHI;
			sfu_pkg::ST_RHI:   state_d = sfu_pkg::ST_RCAP;
			sfu_pkg::ST_RCAP:  state_d = sfu_pkg::ST_EMIT;
			sfu_pkg::ST_EMIT: begin
				if (stat.out_free) state_d = is_last ? sfu_pkg::ST_IDLE : sfu_pkg::ST_ADDR;
			end
			default: state_d = sfu_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		dcmd.op = sfu_pkg::DP_NOP;
		dcmd.acc = acc;
		dcmd.sel = sel;
		dcmd.latch_fp = latch_fp;
		dcmd.last = is_last;
		req_stall = 1'b1;
		unique case (state_q)
			sfu_pkg::ST_CLEAR: dcmd.op = sfu_pkg::DP_CLR;
			sfu_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) dcmd.op = sfu_pkg::DP_LOAD;
			end
			sfu_pkg::ST_ADDR: dcmd.op = sfu_pkg::DP_ADDR;
			sfu_pkg::ST_WLO:  dcmd.op = sfu_pkg::DP_WR_LO;
			sfu_pkg::ST_WHI:  dcmd.op = sfu_pkg::DP_WR_HI;
			sfu_pkg::ST_RLO:  dcmd.op = sfu_pkg::DP_RD_LO;
			sfu_pkg::ST_RHI:  dcmd.op = sfu_pkg::DP_RD_HI;
			sfu_pkg::ST_RCAP: dcmd.op = sfu_pkg::DP_RD_CAP;
			sfu_pkg::ST_EMIT: if (stat.out_free) dcmd.op = sfu_pkg::DP_EMIT;
			default: dcmd.op = sfu_pkg::DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfu_pkg::ST_CLEAR;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == sfu_pkg::ST_IDLE) step_q <= '0;
			else if (state_q == sfu_pkg::ST_EMIT && stat.out_free) step_q <= step_q + 6'd1;
		end
	end

endmodule

/* hw/rtl/sfu_dpath.sv */
// ----------------------------------------------------------------------------
// sfu_dpath
// Register file, stack byte store and result register of the stack frame
// unit. Performs one micro step per command from the sequencer.
// ----------------------------------------------------------------------------
module sfu_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  sfu_pkg::req_t     req,
	input  sfu_pkg::dp_cmd_t  dcmd,
	output sfu_pkg::dp_stat_t stat,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output sfu_pkg::rsp_t     rsp
);

	localparam int DEPTH = 2 ** sfu_pkg::STORE_AW;
	localparam logic [sfu_pkg::STORE_AW-1:0] IDX_ONE = {{(sfu_pkg::STORE_AW-1){1'b0}}, 1'b1};

	logic [7:0] mem [DEPTH];
	logic [sfu_pkg::STORE_AW-1:0] clr_q;
	logic [15:0] r_q [8];
	logic [15:0] ss_q, sp0_q, tmp_q, fp_q, cp_q, frame_q;
	logic [7:0] level_q;
	logic [1:0] cmd_q;
	logic [19:0] addr_q;
	logic [15:0] data_q;
	logic kind_q;
	logic [7:0] rd_q, lo_q;
	logic rsp_valid_q;
	sfu_pkg::rsp_t rsp_q;

	logic [15:0] src, sp_dec, cp_dec, pop_base;
	logic [sfu_pkg::STORE_AW-1:0] lo_idx, hi_idx;
	logic we, re;
	logic [sfu_pkg::STORE_AW-1:0] wa, ra;
	logic [7:0] wd;
	logic [15:0] word;

	function automatic logic [19:0] phys(input logic [15:0] seg, input logic [15:0] off);
		phys = {seg, 4'b0000} + {4'b0000, off};
	endfunction

	assign sp_dec = r_q[sfu_pkg::SEL_SP[2:0]] - 16'd2;
	assign cp_dec = cp_q - 16'd2;
	assign lo_idx = addr_q[sfu_pkg::STORE_AW-1:0];
	// high byte sits at the next 20-bit address, which wraps into the store as well
	assign hi_idx = lo_idx + IDX_ONE;
	assign word = {rd_q, lo_q};

	always_comb begin
		case (dcmd.acc)
			sfu_pkg::ACC_POP_SKIP: pop_base = r_q[sfu_pkg::SEL_SP[2:0]] + 16'd2;
			sfu_pkg::ACC_LEAVE:    pop_base = r_q[sfu_pkg::SEL_BP[2:0]];
			default:               pop_base = r_q[sfu_pkg::SEL_SP[2:0]];
		endcase
		case (dcmd.sel)
			sfu_pkg::SEL_SP0: src = sp0_q;
			sfu_pkg::SEL_TMP: src = tmp_q;
			sfu_pkg::SEL_FP:  src = fp_q;
			default:          src = r_q[dcmd.sel[2:0]];
		endcase
	end

	always_comb begin
		we = 1'b0;
		wa = lo_idx;
		wd = data_q[7:0];
		re = 1'b0;
		ra = lo_idx;
		case (dcmd.op)
			sfu_pkg::DP_CLR: begin
				we = 1'b1;
				wa = clr_q;
				wd = 8'd0;
			end
			sfu_pkg::DP_WR_LO: we = 1'b1;
			sfu_pkg::DP_WR_HI: begin
				we = 1'b1;
				wa = hi_idx;
				wd = data_q[15:8];
			end
			sfu_pkg::DP_RD_LO: re = 1'b1;
			sfu_pkg::DP_RD_HI: begin
				re = 1'b1;
				ra = hi_idx;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (dcmd.op == sfu_pkg::DP_CLR) begin
			clr_q <= clr_q + IDX_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= sfu_pkg::CMD_PUSHA;
			level_q <= '0;
		end else if (dcmd.op == sfu_pkg::DP_LOAD) begin
			cmd_q <= req.cmd;
			level_q <= req.nest_level;
		end
	end

	always_ff @(posedge clk) begin
		case (dcmd.op)
			sfu_pkg::DP_LOAD: begin
				ss_q <= req.stack_seg;
				r_q[0] <= req.reg_ax;
				r_q[1] <= req.reg_cx;
				r_q[2] <= req.reg_dx;
				r_q[3] <= req.reg_bx;
				r_q[4] <= req.reg_sp;
				r_q[5] <= req.reg_bp;
				r_q[6] <= req.reg_si;
				r_q[7] <= req.reg_di;
				sp0_q <= req.reg_sp;
				cp_q <= req.reg_bp;
				frame_q <= req.frame_bytes;
			end
			sfu_pkg::DP_ADDR: begin
				case (dcmd.acc)
					sfu_pkg::ACC_PUSH: begin
						r_q[sfu_pkg::SEL_SP[2:0]] <= sp_dec;
						addr_q <= phys(ss_q, sp_dec);
						data_q <= src;
						kind_q <= sfu_pkg::ACCESS_WRITE;
						if (dcmd.latch_fp) fp_q <= sp_dec;
					end
					sfu_pkg::ACC_COPY: begin
						cp_q <= cp_dec;
						addr_q <= phys(ss_q, cp_dec);
						kind_q <= sfu_pkg::ACCESS_READ;
					end
					default: begin
						r_q[sfu_pkg::SEL_SP[2:0]] <= pop_base + 16'd2;
						addr_q <= phys(ss_q, pop_base);
						kind_q <= sfu_pkg::ACCESS_READ;
					end
				endcase
			end
			sfu_pkg::DP_RD_HI: lo_q <= rd_q;
			sfu_pkg::DP_RD_CAP: begin
				data_q <= word;
				if (dcmd.sel == sfu_pkg::SEL_TMP) tmp_q <= word;
				else r_q[dcmd.sel[2:0]] <= word;
			end
			default: ;
		endcase
	end

	// result register; ENTER settles BP and SP on its last access
	always_ff @(posedge clk) begin
		if (dcmd.op == sfu_pkg::DP_EMIT) begin
			rsp_q.access_kind <= kind_q;
			rsp_q.access_addr <= addr_q;
			rsp_q.access_data <= data_q;
			rsp_q.last <= dcmd.last;
			if (dcmd.last) begin
				rsp_q.new_ax <= r_q[0];
				rsp_q.new_cx <= r_q[1];
				rsp_q.new_dx <= r_q[2];
				rsp_q.new_bx <= r_q[3];
				rsp_q.new_sp <= (cmd_q == sfu_pkg::CMD_ENTER) ? r_q[4] - frame_q : r_q[4];
				rsp_q.new_bp <= (cmd_q == sfu_pkg::CMD_ENTER) ? fp_q : r_q[5];
				rsp_q.new_si <= r_q[6];
				rsp_q.new_di <= r_q[7];
			end else begin
				rsp_q.new_ax <= '0;
				rsp_q.new_cx <= '0;
				rsp_q.new_dx <= '0;
				rsp_q.new_bx <= '0;
				rsp_q.new_sp <= '0;
				rsp_q.new_bp <= '0;
				rsp_q.new_si <= '0;
				rsp_q.new_di <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (dcmd.op == sfu_pkg::DP_EMIT) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assign stat.cmd = cmd_q;
	assign stat.level = level_q;
	assign stat.clr_last = (clr_q == '1);
	assign stat.out_free = !rsp_valid_q || !rsp_stall;

endmodule

/* hw/rtl/x86_stack_frame_unit_core.sv */
// ----------------------------------------------------------------------------
// x86_stack_frame_unit_core
// 80186 PUSHA / POPA / ENTER / LEAVE stack frame engine.
//
// req channel: one instruction per transaction (opcode, SS, register file,
// ENTER frame size and nesting level). req_stall is high while an
// instruction is in progress. rsp channel: one transaction per stack word
// read or written, in program order; the final one has last set and the
// updated registers, earlier ones carry zero registers.
// Each word access passes ST_ADDR, its byte states (ST_WLO, ST_WHI for a
// write; ST_RLO, ST_RHI, ST_RCAP for a read) and ST_EMIT, set by the
// single-port byte store moving one byte per cycle; instructions are
// accepted in ST_IDLE. ENTER makes up to 62 accesses (32 writes, 30 reads).
// After reset a clearing pass zeroes the 64K byte store, one byte per cycle;
// req_stall stays high until it finishes.
// A stalled result holds in the output register; the engine waits at the
// next result until it is taken.
// ----------------------------------------------------------------------------
module x86_stack_frame_unit_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sfu_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sfu_pkg::rsp_t rsp
);

	sfu_pkg::dp_cmd_t  dcmd;
	sfu_pkg::dp_stat_t stat;

	sfu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.dcmd      (dcmd)
	);

	sfu_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.dcmd      (dcmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

/* tb/x86_stack_frame_unit_core_test.sv */
// ----------------------------------------------------------------------------
// x86_stack_frame_unit_core_test
// Checks the stack frame engine (PUSHA, POPA, ENTER, LEAVE) against a local
// predictor with its own byte stack image. A directed table runs first, then
// random instructions, with random gaps and stalls and one long output hold.
// ----------------------------------------------------------------------------
module x86_stack_frame_unit_core_test;

	localparam int MEM_BYTES = 65536;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int N_RANDOM = 200;

	typedef struct {
		sfu_pkg::req_t instr;
		logic has_known;
		sfu_pkg::rsp_t known;  // typed-in final result
	} row_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	sfu_pkg::req_t req = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b1;
	sfu_pkg::rsp_t rsp;

	logic [7:0]    stack_image[MEM_BYTES];
	sfu_pkg::rsp_t pending_accesses[$];
	int            error_count = 0;
	int            cycle_count = 0;
	bit            stim_done = 1'b0;
	bit            hold_rsp = 1'b0;
	row_t          rows[$];

	x86_stack_frame_unit_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report(input string what);
		$display("MISMATCH @%0d: %s", cycle_count, what);
		error_count++;
	endtask

	function automatic logic [19:0] phys_addr(logic [15:0] seg, logic [15:0] off);
		return {seg, 4'h0} + {4'h0, off};
	endfunction

	function automatic logic [15:0] image_rd(logic [19:0] a);
		logic [19:0] b;
		b = a + 20'd1;
		return {stack_image[b % MEM_BYTES], stack_image[a % MEM_BYTES]};
	endfunction

	function automatic void image_wr(logic [19:0] a, logic [15:0] v);
		logic [19:0] b;
		b = a + 20'd1;
		stack_image[a % MEM_BYTES] = v[7:0];
		stack_image[b % MEM_BYTES] = v[15:8];
	endfunction

	function automatic void add_access(logic kind, logic [19:0] a, logic [15:0] d);
		sfu_pkg::rsp_t r;
		r = '0;
		r.access_kind = kind;
		r.access_addr = a;
		r.access_data = d;
		pending_accesses.push_back(r);
	endfunction

	function automatic void push_word(logic [15:0] ss, ref logic [15:0] sp,
			input logic [15:0] v);
		sp = sp - 16'd2;
		image_wr(phys_addr(ss, sp), v);
		add_access(sfu_pkg::ACCESS_WRITE, phys_addr(ss, sp), v);
	endfunction

	function automatic logic [15:0] pop_word(logic [15:0] ss, ref logic [15:0] sp);
		logic [15:0] v;
		v = image_rd(phys_addr(ss, sp));
		add_access(sfu_pkg::ACCESS_READ, phys_addr(ss, sp), v);
		sp = sp + 16'd2;
		return v;
	endfunction

	// appends every word access of one instruction to pending_accesses
	function automatic void predict_frame_op(sfu_pkg::req_t q);
		logic [15:0] ax, cx, dx, bx, sp, bp, si, di, fp, cp, v;
		int n;
		ax = q.reg_ax; cx = q.reg_cx; dx = q.reg_dx; bx = q.reg_bx;
		sp = q.reg_sp; bp = q.reg_bp; si = q.reg_si; di = q.reg_di;
		case (q.cmd)
			sfu_pkg::CMD_PUSHA: begin
				push_word(q.stack_seg, sp, ax);
				push_word(q.stack_seg, sp, cx);
				push_word(q.stack_seg, sp, dx);
				push_word(q.stack_seg, sp, bx);
				push_word(q.stack_seg, sp, q.reg_sp);
				push_word(q.stack_seg, sp, bp);
				push_word(q.stack_seg, sp, si);
				push_word(q.stack_seg, sp, di);
			end
			sfu_pkg::CMD_POPA: begin
				di = pop_word(q.stack_seg, sp);
				si = pop_word(q.stack_seg, sp);
				bp = pop_word(q.stack_seg, sp);
				sp = sp + 16'd2;  // saved SP is skipped, not read
				bx = pop_word(q.stack_seg, sp);
				dx = pop_word(q.stack_seg, sp);
				cx = pop_word(q.stack_seg, sp);
				ax = pop_word(q.stack_seg, sp);
			end
			sfu_pkg::CMD_ENTER: begin
				cp = bp;
				push_word(q.stack_seg, sp, bp);
				fp = sp;
				if (q.nest_level != 8'd0) begin
					n = q.nest_level % 32;
					for (int c = 1; c < n; c++) begin
						cp = cp - 16'd2;
						v = image_rd(phys_addr(q.stack_seg, cp));
						add_access(sfu_pkg::ACCESS_READ, phys_addr(q.stack_seg, cp), v);
						push_word(q.stack_seg, sp, v);
					end
					push_word(q.stack_seg, sp, fp);
				end
				bp = fp;
				sp = sp - q.frame_bytes;
			end
			default: begin
				sp = bp;
				bp = pop_word(q.stack_seg, sp);
			end
		endcase
		begin
			sfu_pkg::rsp_t r;
			r = pending_accesses.pop_back();
			r.last = 1'b1;
			r.new_ax = ax; r.new_cx = cx; r.new_dx = dx; r.new_bx = bx;
			r.new_sp = sp; r.new_bp = bp; r.new_si = si; r.new_di = di;
			pending_accesses.push_back(r);
		end
	endfunction

	function automatic sfu_pkg::req_t rand_req(bit keep_small);
		sfu_pkg::req_t q;
		q.cmd = 2'($urandom_range(0, 3));
		q.stack_seg = 16'($urandom);
		q.reg_ax = 16'($urandom); q.reg_cx = 16'($urandom); q.reg_dx = 16'($urandom);
		q.reg_bx = 16'($urandom); q.reg_sp = 16'($urandom); q.reg_bp = 16'($urandom);
		q.reg_si = 16'($urandom); q.reg_di = 16'($urandom);
		q.frame_bytes = 16'($urandom);
		q.nest_level = 8'($urandom);
		if (keep_small && ($urandom_range(0, 9) != 0))
			q.nest_level = {q.nest_level[7:5], 2'b00, q.nest_level[2:0]};
		// often reuse a nearby stack to read back earlier writes
		if ($urandom_range(0, 2) != 0) begin
			q.stack_seg = 16'h1000;
			q.reg_sp = 16'h0800 + 16'(2 * $urandom_range(0, 64));
			q.reg_bp = q.reg_sp + 16'(2 * $urandom_range(0, 16));
		end
		return q;
	endfunction

	function automatic sfu_pkg::req_t mk(logic [1:0] cmd, logic [15:0] ss, logic [15:0] sp,
			logic [15:0] bp, logic [15:0] fb, logic [7:0] lvl, logic [15:0] fill);
		sfu_pkg::req_t q;
		q = '{cmd, ss, fill, fill ^ 16'h1111, fill ^ 16'h2222, fill ^ 16'h3333,
			sp, bp, fill ^ 16'h4444, fill ^ 16'h5555, fb, lvl};
		return q;
	endfunction

	initial begin
		sfu_pkg::rsp_t z;
		z = '0;
		// POPA right after reset reads the cleared store: all popped registers are zero
		rows.push_back('{mk(sfu_pkg::CMD_POPA, 16'h0000, 16'h0100, 16'h0000, 16'h0, 8'd0,
			16'h0), 1'b1, '{sfu_pkg::ACCESS_READ, 20'h0010E, 16'h0, 1'b1, 16'h0, 16'h0,
			16'h0, 16'h0, 16'h0110, 16'h0, 16'h0, 16'h0}});
		// LEAVE with zero store: BP pops as zero
		rows.push_back('{mk(sfu_pkg::CMD_LEAVE, 16'hFFFF, 16'h1234, 16'h0000, 16'h0, 8'd0,
			16'h0), 1'b1, '{sfu_pkg::ACCESS_READ, 20'hFFFF0, 16'h0, 1'b1, 16'h0, 16'h1111,
			16'h2222, 16'h3333, 16'h0002, 16'h0, 16'h4444, 16'h5555}});
		rows.push_back('{mk(sfu_pkg::CMD_PUSHA, 16'hFFFF, 16'h0010, 16'h0, 16'h0, 8'd0,
			16'hFFFF), 1'b0, z});
		rows.push_back('{mk(sfu_pkg::CMD_POPA, 16'hFFFF, 16'h0000, 16'h0, 16'h0, 8'd0,
			16'h0), 1'b0, z});
		rows.push_back('{mk(sfu_pkg::CMD_PUSHA, 16'h0000, 16'h0000, 16'hFFFF, 16'h0, 8'd0,
			16'hA5A5), 1'b0, z});
		rows.push_back('{mk(sfu_pkg::CMD_POPA, 16'h0000, 16'hFFF0, 16'h0, 16'h0, 8'd0,
			16'h0), 1'b0, z});
		rows.push_back('{mk(sfu_pkg::CMD_ENTER, 16'h2000, 16'h0400, 16'h0420, 16'h0, 8'd0,
			16'h1), 1'b0, z});
		rows.push_back('{mk(sfu_pkg::CMD_ENTER, 16'h2000, 16'h0400, 16'h0420, 16'hFFFF, 8'd1,
			16'h2), 1'b0, z});
		rows.push_back('{mk(sfu_pkg::CMD_ENTER, 16'h2000, 16'h0400, 16'h0420, 16'h10, 8'd3,
			16'h3), 1'b0, z});
		rows.push_back('{mk(sfu_pkg::CMD_ENTER, 16'h2000, 16'h0400, 16'h0480, 16'h0, 8'd31,
			16'h4), 1'b0, z});
		rows.push_back('{mk(sfu_pkg::CMD_ENTER, 16'h2000, 16'h0400, 16'h0480, 16'h8, 8'd32,
			16'h5), 1'b0, z});
		rows.push_back('{mk(sfu_pkg::CMD_ENTER, 16'h2000, 16'h0400, 16'h0480, 16'h8, 8'd255,
			16'h6), 1'b0, z});
		rows.push_back('{mk(sfu_pkg::CMD_ENTER, 16'h2000, 16'h0400, 16'h0480, 16'h8, 8'd128,
			16'h7), 1'b0, z});
		rows.push_back('{mk(sfu_pkg::CMD_LEAVE, 16'h2000, 16'h0000, 16'h03FE, 16'h0, 8'd0,
			16'h8), 1'b0, z});
		rows.push_back('{mk(sfu_pkg::CMD_LEAVE, 16'h0FFF, 16'h0, 16'hFFFF, 16'h0, 8'd0,
			16'h9), 1'b0, z});
		rows.push_back('{mk(sfu_pkg::CMD_ENTER, 16'hFFFF, 16'h0002, 16'h0004, 16'h0, 8'd4,
			16'hA), 1'b0, z});
		rows.push_back('{mk(sfu_pkg::CMD_PUSHA, 16'hF000, 16'h0, 16'h0, 16'h0, 8'd0,
			16'h0000), 1'b0, z});
		rows.push_back('{mk(sfu_pkg::CMD_POPA, 16'hF000, 16'hFFF0, 16'h0, 16'h0, 8'd0,
			16'h0), 1'b0, z});
	end

	// sender: table first, then random; a random gap, possibly none, before each transaction
	initial begin
		sfu_pkg::req_t q;
		int gap;
		for (int i = 0; i < MEM_BYTES; i++)
			stack_image[i] = 8'h00;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < rows.size() + N_RANDOM; i++) begin
			q = (i < rows.size()) ? rows[i].instr : rand_req(1'b1);
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 16));
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			req_valid <= 1'b1;
			req <= q;
			do @(posedge clk); while (!(req_valid && !req_stall));
			predict_frame_op(q);
			if (i < rows.size() && rows[i].has_known) begin
				sfu_pkg::rsp_t k;
				k = pending_accesses[pending_accesses.size() - 1];
				if (k !== rows[i].known)
					report($sformatf("row %0d table value %h, predictor %h", i,
						rows[i].known, k));
			end
			// long receiver hold while the sender keeps offering
			if (i == rows.size() + 20)
				hold_rsp = 1'b1;
		end
		req_valid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		wait (hold_rsp);
		repeat (600) @(posedge clk);
		hold_rsp = 1'b0;
	end

	// receiver: random stall stretches, compare on each accepted transaction
	initial begin
		int wait_cycles;
		sfu_pkg::rsp_t e;
		@(posedge arst_n);
		forever begin
			wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 16));
			if (wait_cycles != 0 || hold_rsp) begin
				rsp_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
				while (hold_rsp) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			if (pending_accesses.size() == 0) begin
				report($sformatf("unexpected access %h", rsp));
			end else begin
				e = pending_accesses.pop_front();
				if (rsp.access_kind !== e.access_kind)
					report($sformatf("kind %b exp %b", rsp.access_kind, e.access_kind));
				if (rsp.access_addr !== e.access_addr)
					report($sformatf("addr %h exp %h", rsp.access_addr, e.access_addr));
				if (rsp.access_data !== e.access_data)
					report($sformatf("data %h exp %h", rsp.access_data, e.access_data));
				if (rsp.last !== e.last)
					report($sformatf("last %b exp %b", rsp.last, e.last));
				if (rsp.new_ax !== e.new_ax)
					report($sformatf("ax %h exp %h", rsp.new_ax, e.new_ax));
				if (rsp.new_cx !== e.new_cx)
					report($sformatf("cx %h exp %h", rsp.new_cx, e.new_cx));
				if (rsp.new_dx !== e.new_dx)
					report($sformatf("dx %h exp %h", rsp.new_dx, e.new_dx));
				if (rsp.new_bx !== e.new_bx)
					report($sformatf("bx %h exp %h", rsp.new_bx, e.new_bx));
				if (rsp.new_sp !== e.new_sp)
					report($sformatf("sp %h exp %h", rsp.new_sp, e.new_sp));
				if (rsp.new_bp !== e.new_bp)
					report($sformatf("bp %h exp %h", rsp.new_bp, e.new_bp));
				if (rsp.new_si !== e.new_si)
					report($sformatf("si %h exp %h", rsp.new_si, e.new_si));
				if (rsp.new_di !== e.new_di)
					report($sformatf("di %h exp %h", rsp.new_di, e.new_di));
			end
		end
	end

	initial begin
		wait (stim_done);
		while (pending_accesses.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (error_count == 0 && pending_accesses.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
